@@ rtl/core/ksd_pkg.sv @@
// Shared constants, types and the key lookup table for the scancode decoder.
package ksd_pkg;

    // Default character FIFO depth (ring holds one less than this)
    localparam int FIFO_DEPTH_DEF = 64;

    // Field widths
    localparam int CODE_W = 8;
    localparam int KEY_W  = 7;
    localparam int CHAR_W = 7;
    localparam int IDX_W  = 2;

    // Request kinds carried on s_tuser
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Scancode set 1 key codes (release bit stripped)
    localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3A;
    localparam logic [KEY_W-1:0] KEY_ALT    = 7'h38;
    localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1D;
    localparam logic [KEY_W-1:0] KEY_BKSP   = 7'h0E;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 7'h1C;
    localparam logic [KEY_W-1:0] KEY_F1     = 7'h3B;
    localparam logic [KEY_W-1:0] KEY_F4     = 7'h3E;

    // Characters with special meaning
    localparam logic [CHAR_W-1:0] CH_BKSP  = 7'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_CASE  = 7'h20;

    // Decoder to FIFO push request
    typedef struct packed {
        logic              push;
        logic [CHAR_W-1:0] ch;
    } push_req_t;

    // Console switch report from the decoder
    typedef struct packed {
        logic             switch_request;
        logic [IDX_W-1:0] console_index;
    } switch_t;

    // FIFO status for the current request
    typedef struct packed {
        logic char_valid;
        logic char_dropped;
    } fifo_stat_t;

    // Lowercase key map, zero for keys that give no character
    function automatic logic [CHAR_W-1:0] key_rom(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] c;
        unique case (key)
            7'h02: c = 7'h31; // 1
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30; // 0
            7'h0C: c = 7'h2D; // -
            7'h0D: c = 7'h3D; // =
            7'h10: c = 7'h71; // q
            7'h11: c = 7'h77; // w
            7'h12: c = 7'h65; // e
            7'h13: c = 7'h72; // r
            7'h14: c = 7'h74; // t
            7'h15: c = 7'h79; // y
            7'h16: c = 7'h75; // u
            7'h17: c = 7'h69; // i
            7'h18: c = 7'h6F; // o
            7'h19: c = 7'h70; // p
            7'h1A: c = 7'h5B; // [
            7'h1B: c = 7'h5D; // ]
            7'h1E: c = 7'h61; // a
            7'h1F: c = 7'h73; // s
            7'h20: c = 7'h64; // d
            7'h21: c = 7'h66; // f
            7'h22: c = 7'h67; // g
            7'h23: c = 7'h68; // h
            7'h24: c = 7'h6A; // j
            7'h25: c = 7'h6B; // k
            7'h26: c = 7'h6C; // l
            7'h27: c = 7'h3B; // ;
            7'h28: c = 7'h27; // quote
            7'h29: c = 7'h60; // backtick
            7'h2B: c = 7'h5C; // backslash
            7'h2C: c = 7'h7A; // z
            7'h2D: c = 7'h78; // x
            7'h2E: c = 7'h63; // c
            7'h2F: c = 7'h76; // v
            7'h30: c = 7'h62; // b
            7'h31: c = 7'h6E; // n
            7'h32: c = 7'h6D; // m
            7'h33: c = 7'h2C; // ,
            7'h34: c = 7'h2E; // .
            7'h35: c = 7'h2F; // /
            7'h37: c = 7'h2A; // *
            7'h39: c = 7'h20; // space
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/keyboard_scancode_decoder_fifo_unit.sv @@
// Top level of the keyboard scancode decoder with character FIFO.
//
//  channel | dir | tdata                      | tuser
//  --------+-----+----------------------------+------------------------
//  s_*     | in  | [7:0] scancode             | [0] opcode (0 scan, 1 read)
//  m_*     | out | [0] char_valid [7:1] char_out [8] switch_request
//          |     | [10:9] console_index [11] char_dropped [15:12] zero
//
// One request per cycle unless the result stalls, through an input register,
// then decode and FIFO push or pop feeding the result register (the FIFO
// read port registers its data alongside). Reset clears modifiers, pointers
// and both valid flags; FIFO contents are left as they are. A stalled result
// holds both stages; the input side keeps taking requests while stage 1 is
// free or moving on.
module keyboard_scancode_decoder_fifo_unit #(
    parameter int FIFO_DEPTH = ksd_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] char_valid, [7:1] char_out, [8] switch_request,
                                   // [10:9] console_index, [11] char_dropped, [15:12] zero
);

    logic                        s1_valid_reg;
    logic                        s1_op_reg;
    logic [ksd_pkg::CODE_W-1:0]  s1_code_reg;
    logic                        m_valid_reg;
    ksd_pkg::fifo_stat_t         m_stat_reg;
    ksd_pkg::switch_t            m_sw_reg;
    logic                        adv;
    logic                        en;
    ksd_pkg::push_req_t          push_req;
    ksd_pkg::switch_t            sw;
    ksd_pkg::fifo_stat_t         stat;
    logic [ksd_pkg::CHAR_W-1:0]  rd_data;
    logic [ksd_pkg::CHAR_W-1:0]  char_out;

    // Pipeline flow control
    assign adv      = !m_valid_reg || m_tready;
    assign en       = s1_valid_reg && adv;
    assign s_tready = !s1_valid_reg || adv;

    ksd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .opcode   (s1_op_reg),
        .scancode (s1_code_reg),
        .push_req (push_req),
        .sw       (sw)
    );

    ksd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .pop_req  (s1_op_reg == ksd_pkg::OP_READ),
        .push_req (push_req),
        .stat     (stat),
        .rd_data  (rd_data)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (adv)
                m_valid_reg <= s1_valid_reg;
        end
    end

    // Input and result payload
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            s1_op_reg   <= s_tuser[0];
            s1_code_reg <= s_tdata;
        end
        if (adv)
        begin
            m_stat_reg <= stat;
            m_sw_reg   <= sw;
        end
    end

    // Popped character shows only on a successful read
    assign char_out = rd_data & {ksd_pkg::CHAR_W{m_stat_reg.char_valid}};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000,
                       m_stat_reg.char_dropped,
                       m_sw_reg.console_index,
                       m_sw_reg.switch_request,
                       char_out,
                       m_stat_reg.char_valid};

endmodule

@@ rtl/core/ksd_decode.sv @@
// Scancode decoder: modifier tracking, key map and console switch detection.
module ksd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,        // request in stage 1 moves on
    input  logic                       opcode,
    input  logic [ksd_pkg::CODE_W-1:0] scancode,
    output ksd_pkg::push_req_t         push_req,
    output ksd_pkg::switch_t           sw
);

    logic                       shift_reg, shift_next;
    logic                       caps_reg, caps_next;
    logic                       alt_reg, alt_next;
    logic                       rel;
    logic [ksd_pkg::KEY_W-1:0]  key;
    logic [ksd_pkg::CHAR_W-1:0] rom_ch;
    logic [ksd_pkg::CHAR_W-1:0] ch;

    assign rel    = scancode[ksd_pkg::CODE_W-1];
    assign key    = scancode[ksd_pkg::KEY_W-1:0];
    assign rom_ch = ksd_pkg::key_rom(key);

    // Key classification and character selection
    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        alt_next   = alt_reg;
        ch         = '0;
        sw         = '0;
        if (opcode == ksd_pkg::OP_SCAN)
        begin
            priority if (key == ksd_pkg::KEY_LSHIFT || key == ksd_pkg::KEY_RSHIFT)
            begin
                shift_next = !rel;
            end
            else if (key == ksd_pkg::KEY_CAPS)
            begin
                if (!rel)
                    caps_next = !caps_reg;
            end
            else if (key == ksd_pkg::KEY_ALT)
            begin
                alt_next = !rel;
            end
            else if (key == ksd_pkg::KEY_CTRL)
            begin
                ch = '0;  // ctrl is swallowed
            end
            else if (!rel)
            begin
                priority if (key == ksd_pkg::KEY_BKSP)
                begin
                    ch = ksd_pkg::CH_BKSP;
                end
                else if (key == ksd_pkg::KEY_ENTER)
                begin
                    ch = ksd_pkg::CH_LF;
                end
                else if (alt_reg && key >= ksd_pkg::KEY_F1 && key <= ksd_pkg::KEY_F4)
                begin
                    sw.switch_request = 1'b1;
                    sw.console_index  = ksd_pkg::IDX_W'(key - ksd_pkg::KEY_F1);
                end
                else
                begin
                    ch = rom_ch;
                    if (rom_ch >= ksd_pkg::CH_LOW_A && rom_ch <= ksd_pkg::CH_LOW_Z &&
                        (shift_reg ^ caps_reg))
                        ch = rom_ch - ksd_pkg::CH_CASE;
                end
            end
        end
        push_req.push = (ch != '0);
        push_req.ch   = ch;
    end

    // Modifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
            alt_reg   <= 1'b0;
        end
        else if (en)
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
            alt_reg   <= alt_next;
        end
    end

endmodule

@@ rtl/core/ksd_fifo.sv @@
// Character ring FIFO: storage, pointers, full/empty and registered read data.
module ksd_fifo #(
    parameter int FIFO_DEPTH = ksd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,        // request in stage 1 moves on
    input  logic                       pop_req,
    input  ksd_pkg::push_req_t         push_req,
    output ksd_pkg::fifo_stat_t        stat,
    output logic [ksd_pkg::CHAR_W-1:0] rd_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [ksd_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [ksd_pkg::CHAR_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]           wr_ptr_inc;
    logic [PTR_W-1:0]           rd_ptr_inc;
    logic                       empty;
    logic                       full;
    logic                       do_push;
    logic                       do_pop;

    // Ring pointer arithmetic, wraps at the depth
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_inc == rd_ptr_reg);

    assign do_push = en && push_req.push && !full;
    assign do_pop  = en && pop_req && !empty;

    assign wr_ptr_next = do_push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = do_pop  ? rd_ptr_inc : rd_ptr_reg;

    assign stat.char_valid   = pop_req && !empty;
    assign stat.char_dropped = push_req.push && full;
    assign rd_data           = rd_data_reg;

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage write port
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_req.ch;
    end

    // Storage read port, lands with the result register
    always_ff @(posedge clk)
    begin
        if (en)
            rd_data_reg <= mem[rd_ptr_reg];
    end

endmodule

@@ rtl/core/ksd_checker.sv @@
// Port-level checker for the scancode decoder, bound to the top level.
module ksd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // No character without a successful read
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
        else $error("character shown without char_valid");

    // Console index only with a switch request
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tdata[10:9] == 2'd0)
        else $error("console index without switch request");

    // A read result carries no scancode flags, and a switch never drops
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[8] || m_tdata[11])) &&
                     !(m_tdata[8] && m_tdata[11]))
        else $error("result flags conflict");

    // Padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("padding bits set");

endmodule

bind keyboard_scancode_decoder_fifo_unit ksd_checker u_ksd_checker (.*);

@@ tb/sv/keyboard_scancode_decoder_fifo_unit_test.sv @@
// Self-checking testbench for the keyboard scancode decoder with character FIFO.
module keyboard_scancode_decoder_fifo_unit_test;

    import ksd_pkg::*;

    localparam int STORE_SLOTS  = FIFO_DEPTH_DEF - 1;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // Lowercase characters per key code 0x00..0x3F, zero where no character
    localparam logic [CHAR_W-1:0] KEY_CHARS [64] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] code;
    } kbd_request_t;

    typedef struct {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic              sw;
        logic [IDX_W-1:0]  idx;
        logic              drop;
    } kbd_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] char_valid, [7:1] char_out, [8] switch_request,
                                    // [10:9] console_index, [11] char_dropped, [15:12] zero

    // Request stream and expected results
    kbd_request_t pending_reqs[$];
    kbd_result_t  expected_results[$];
    kbd_request_t next_req;
    kbd_result_t  want;
    int           total_reqs;
    int           sent_count;
    int           fail_count;
    int           cycle_count;

    // Shadow of the decoder state
    logic              shift_held;
    logic              caps_on;
    logic              alt_held;
    logic [CHAR_W-1:0] typed_chars[$];

    keyboard_scancode_decoder_fifo_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Decode one request against the shadow state
    function automatic kbd_result_t decode_request(input logic op, input logic [7:0] code);
        kbd_result_t       res;
        logic [KEY_W-1:0]  key;
        logic              rel;
        logic [CHAR_W-1:0] c;
        res = '{valid: 1'b0, ch: '0, sw: 1'b0, idx: '0, drop: 1'b0};
        key = code[6:0];
        rel = code[7];
        c   = '0;
        if (op == OP_READ)
        begin
            if (typed_chars.size() > 0)
            begin
                res.valid = 1'b1;
                res.ch    = typed_chars.pop_front();
            end
        end
        else if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            shift_held = !rel;
        else if (key == KEY_CAPS)
        begin
            if (!rel)
                caps_on = !caps_on;
        end
        else if (key == KEY_ALT)
            alt_held = !rel;
        else if (key != KEY_CTRL && !rel)
        begin
            if (key == KEY_BKSP)
                c = CH_BKSP;
            else if (key == KEY_ENTER)
                c = CH_LF;
            else if (alt_held && key >= KEY_F1 && key <= KEY_F4)
            begin
                res.sw  = 1'b1;
                res.idx = IDX_W'(key - KEY_F1);
            end
            else
            begin
                c = key[6] ? '0 : KEY_CHARS[key[5:0]];
                if (c >= CH_LOW_A && c <= CH_LOW_Z && (shift_held != caps_on))
                    c = c - CH_CASE;
            end
            if (c != '0)
            begin
                if (typed_chars.size() >= STORE_SLOTS)
                    res.drop = 1'b1;
                else
                    typed_chars.push_back(c);
            end
        end
        return res;
    endfunction

    task automatic queue_req(input logic op, input logic [7:0] code);
        pending_reqs.push_back('{op: op, code: code});
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Idle percentages by third of the run: sender then receiver
    function automatic int sender_idle_pct();
        if (sent_count * 3 < total_reqs)
            return 10;
        else if (sent_count * 3 < total_reqs * 2)
            return 77;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (sent_count * 3 < total_reqs)
            return 77;
        else if (sent_count * 3 < total_reqs * 2)
            return 10;
        return 0;
    endfunction

    // Driver: record accepted requests, then present the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(decode_request(s_tuser[0], s_tdata));
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.code;
                    s_tuser  <= next_req.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: tdata %0h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("char_valid", 16'(want.valid), 16'(m_tdata[0]));
                    check_field("char_out", 16'(want.ch), 16'(m_tdata[7:1]));
                    check_field("switch_request", 16'(want.sw), 16'(m_tdata[8]));
                    check_field("console_index", 16'(want.idx), 16'(m_tdata[10:9]));
                    check_field("char_dropped", 16'(want.drop), 16'(m_tdata[11]));
                    check_field("zero_pad", 16'h0, 16'(m_tdata[15:12]));
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int kind;
        int len;
        int r;
        shift_held  = 1'b0;
        caps_on     = 1'b0;
        alt_held    = 1'b0;
        sent_count  = 0;
        fail_count  = 0;
        cycle_count = 0;

        // Directed: empty reads, code extremes, modifiers, specials, switches
        queue_req(OP_READ, 8'hFF);
        queue_req(OP_SCAN, 8'h00);
        queue_req(OP_SCAN, 8'hFF);
        queue_req(OP_SCAN, 8'h1E);
        queue_req(OP_SCAN, 8'h2A);
        queue_req(OP_SCAN, 8'h10);
        queue_req(OP_SCAN, 8'hAA);
        queue_req(OP_SCAN, 8'h3A);
        queue_req(OP_SCAN, 8'hBA);
        queue_req(OP_SCAN, 8'h2C);
        queue_req(OP_SCAN, 8'h36);
        queue_req(OP_SCAN, 8'h32);
        queue_req(OP_SCAN, 8'hB6);
        queue_req(OP_SCAN, 8'h3A);
        queue_req(OP_SCAN, 8'h0E);
        queue_req(OP_SCAN, 8'h1C);
        queue_req(OP_SCAN, 8'h1D);
        queue_req(OP_SCAN, 8'h9D);
        queue_req(OP_SCAN, 8'h3B);
        queue_req(OP_SCAN, 8'h38);
        queue_req(OP_SCAN, 8'h3B);
        queue_req(OP_SCAN, 8'h3E);
        queue_req(OP_SCAN, 8'h3F);
        queue_req(OP_SCAN, 8'hB8);
        queue_req(OP_SCAN, 8'h9E);
        queue_req(OP_READ, 8'h00);

        // Random episodes; the first one is always a typing burst
        kind = 0;
        while (pending_reqs.size() < RANDOM_ITEMS + 26)
        begin
            case (kind)
                0:
                begin
                    // typing burst with modifier changes and rare reads
                    len = $urandom_range(90, 60);
                    repeat (len)
                    begin
                        r = $urandom_range(99);
                        if (r < 4)
                            queue_req(OP_SCAN, $urandom_range(1) ? 8'h2A : 8'h36);
                        else if (r < 8)
                            queue_req(OP_SCAN, $urandom_range(1) ? 8'hAA : 8'hB6);
                        else if (r < 11)
                            queue_req(OP_SCAN, {$urandom_range(1) == 1, KEY_CAPS});
                        else if (r < 16)
                            queue_req(OP_READ, 8'($urandom_range(255)));
                        else if (r < 22)
                            queue_req(OP_SCAN, 8'($urandom_range(255)));
                        else
                            queue_req(OP_SCAN, 8'($urandom_range(8'h39, 8'h02)));
                    end
                end
                1:
                begin
                    // draining burst
                    len = $urandom_range(80, 40);
                    repeat (len)
                    begin
                        if ($urandom_range(99) < 80)
                            queue_req(OP_READ, 8'($urandom_range(255)));
                        else
                            queue_req(OP_SCAN, 8'($urandom_range(8'h39, 8'h02)));
                    end
                end
                2:
                begin
                    // alt held over function keys and others
                    queue_req(OP_SCAN, {1'b0, KEY_ALT});
                    len = $urandom_range(6, 2);
                    repeat (len)
                    begin
                        if ($urandom_range(99) < 60)
                            queue_req(OP_SCAN, 8'($urandom_range(8'h3E, 8'h3B)));
                        else
                            queue_req(OP_SCAN, 8'($urandom_range(8'h7F)));
                    end
                    queue_req(OP_SCAN, {1'b1, KEY_ALT});
                end
                default:
                begin
                    // unstructured noise
                    len = $urandom_range(40, 20);
                    repeat (len)
                        queue_req($urandom_range(1) == 1, 8'($urandom_range(255)));
                end
            endcase
            r = $urandom_range(99);
            kind = (r < 40) ? 0 : (r < 70) ? 1 : (r < 80) ? 2 : 3;
        end
        total_reqs = pending_reqs.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all requests accepted and all results checked
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
